[rtl/timestamped_pose_buffer_lookup_macros.svh]
// Assertion macros shared by the pose buffer modules.
`ifndef TIMESTAMPED_POSE_BUFFER_LOOKUP_MACROS_SVH
`define TIMESTAMPED_POSE_BUFFER_LOOKUP_MACROS_SVH
// Property checked on every rising clock edge outside reset.
`define TPB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check, also active during reset.
`define TPB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/tpb_pkg.sv]
// Package with types and constants of the pose buffer lookup.
package tpb_pkg;
  localparam int unsigned DepthDefault = 256;
  localparam int unsigned CapMin = 50;
  localparam int unsigned TimeW = 48;
  localparam int unsigned PayW = 64;
  localparam int unsigned LocW = 8;
  localparam int unsigned CfgW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [LocW-1:0] LocBad = 8'd2;

  typedef enum logic [2:0] {
    KindPush = 3'd0,
    KindFullQuery = 3'd1,
    KindDrQuery = 3'd2,
    KindClear = 3'd3,
    KindCount = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    StatOk = 2'd0,
    StatNotFound = 2'd1,
    StatTooNew = 2'd2,
    StatBadLoc = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CfgCapacity = 2'd0,
    CfgGapLimit = 2'd1,
    CfgAheadTol = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OpPush,
    OpQuery,
    OpClear,
    OpNone
  } op_e;

  typedef struct packed {
    op_e op;
    logic full_query;
    logic [TimeW-1:0] time_req;
    logic [PayW-1:0] payload;
    logic [LocW-1:0] loc_state;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] found_index;
    logic [PayW-1:0] found_payload;
    logic [LocW-1:0] found_loc_state;
    logic [8:0] entry_count;
  } res_t;
endpackage

[rtl/tpb_in_if.sv]
// Handshake interface for input items.
interface tpb_in_if;
  logic valid;
  logic ready;
  logic [2:0] kind;
  logic [47:0] time_req;
  logic [63:0] payload;
  logic [7:0] loc_state;
  modport source (output valid, kind, time_req, payload, loc_state, input ready);
  modport sink (input valid, kind, time_req, payload, loc_state, output ready);
endinterface

[rtl/tpb_out_if.sv]
// Handshake interface for result items.
interface tpb_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [7:0] found_index;
  logic [63:0] found_payload;
  logic [7:0] found_loc_state;
  logic [8:0] entry_count;
  modport source (output valid, status, found_index, found_payload, found_loc_state,
    entry_count, input ready);
  modport sink (input valid, status, found_index, found_payload, found_loc_state,
    entry_count, output ready);
endinterface

[rtl/tpb_front.sv]
// Front end: classifies input items and queues commands in a short FIFO.
module tpb_front import tpb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tpb_in_if.sink in_if,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);
  cmd_t fifo_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wr_q, wr_d, rd_q, rd_d;
  cmd_t cmd_in;
  logic push, pop;

  always_comb begin
    cmd_in.time_req = in_if.time_req;
    cmd_in.payload = in_if.payload;
    cmd_in.loc_state = in_if.loc_state;
    cmd_in.full_query = (in_if.kind == KindFullQuery);
    unique case (in_if.kind)
      KindPush: cmd_in.op = OpPush;
      KindFullQuery, KindDrQuery: cmd_in.op = OpQuery;
      KindClear: cmd_in.op = OpClear;
      default: cmd_in.op = OpNone;
    endcase
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = fifo_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    wr_d = wr_q ^ push;
    rd_d = rd_q ^ pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_in;
    end
  end

`include "timestamped_pose_buffer_lookup_macros.svh"
  `TPB_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= 2'd2, "queue count overflow")
  `TPB_ASSERT(a_no_push_full, clk_i, rst_ni, (cnt_q == 2'd2) |-> !push, "push into full queue")
  `TPB_ASSERT(a_ptr_match, clk_i, rst_ni, (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q),
    "queue pointers inconsistent")
endmodule

[rtl/tpb_back.sv]
// Back end: ring buffer memories, push handling and binary search lookup.
module tpb_back import tpb_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  input  logic [8:0] capacity_i,
  input  logic [CfgW-1:0] gap_limit_i,
  input  logic [CfgW-1:0] ahead_tol_i,
  tpb_out_if.source out_if
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [3:0] {
    StIdle, StFront, StFrontW, StBackW, StSearch, StSearchW, StAt, StAtW,
    StPrev, StPrevW, StFetch, StFetchW, StOut
  } state_e;

  state_e state_q;
  logic [TimeW-1:0] time_mem [DEPTH];
  logic [PayW-1:0] pay_mem [DEPTH];
  logic [LocW-1:0] loc_mem [DEPTH];

  logic [AW-1:0] oldest_q;
  logic [CW-1:0] held_q;
  cmd_t cmd_q;
  logic [AW-1:0] raddr_q;
  logic [TimeW-1:0] rtime_q;
  logic [PayW-1:0] rpay_q;
  logic [LocW-1:0] rloc_q;
  logic [TimeW-1:0] front_q, at_q;
  logic [CW-1:0] lo_q, hi_q, pos_q;
  res_t res_q;
  res_t out_q;
  logic out_valid_q;

  logic [CW-1:0] cap_eff;
  logic [CW-1:0] mid;
  logic [TimeW:0] diff_back;
  logic [TimeW:0] d_up, d_dn;

  always_comb begin
    if (capacity_i < 9'(CapMin)) begin
      cap_eff = CW'(CapMin);
    end else if (32'(capacity_i) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(capacity_i);
    end
  end

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {1'b0, {(CW - AW){1'b0}}, base} + {1'b0, p};
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign diff_back = {1'b0, cmd_q.time_req} - {1'b0, rtime_q};
  assign d_up = {1'b0, at_q} - {1'b0, cmd_q.time_req};
  assign d_dn = {1'b0, cmd_q.time_req} - {1'b0, rtime_q};

  assign cmd_ready_o = (state_q == StIdle);
  assign out_if.valid = out_valid_q;
  assign out_if.status = out_q.status;
  assign out_if.found_index = out_q.found_index;
  assign out_if.found_payload = out_q.found_payload;
  assign out_if.found_loc_state = out_q.found_loc_state;
  assign out_if.entry_count = out_q.entry_count;

  always_ff @(posedge clk_i) begin
    rtime_q <= time_mem[raddr_q];
    rpay_q <= pay_mem[raddr_q];
    rloc_q <= loc_mem[raddr_q];
  end

  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic [CW-1:0] held_after_clr, held_new;
  logic [AW-1:0] oldest_after_clr, oldest_new;
  logic clr_push;

  always_comb begin
    clr_push = (held_q != '0) &&
               ((cmd_q.time_req < rtime_q) || (diff_back > (TimeW+1)'(gap_limit_i)));
    held_after_clr = clr_push ? '0 : held_q;
    oldest_after_clr = clr_push ? '0 : oldest_q;
    if (held_after_clr >= CW'(DEPTH)) begin
      oldest_new = slot(oldest_after_clr, CW'(1));
      held_new = held_after_clr;
    end else begin
      oldest_new = oldest_after_clr;
      held_new = held_after_clr + CW'(1);
    end
    mem_wa = slot(oldest_new, held_new - CW'(1));
    mem_we = (state_q == StBackW) && (cmd_q.op == OpPush);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem[mem_wa] <= cmd_q.time_req;
      pay_mem[mem_wa] <= cmd_q.payload;
      loc_mem[mem_wa] <= cmd_q.loc_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      oldest_q <= '0;
      held_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (state_q == StOut) || (out_valid_q && !out_if.ready);
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            res_q <= '0;
            unique case (cmd_i.op)
              OpPush: begin
                raddr_q <= slot(oldest_q, held_q - CW'(1));
                state_q <= StFrontW;
              end
              OpQuery: begin
                raddr_q <= oldest_q;
                state_q <= StFront;
              end
              OpClear: begin
                held_q <= '0;
                oldest_q <= '0;
                res_q.entry_count <= '0;
                state_q <= StOut;
              end
              default: begin
                res_q.entry_count <= 9'(held_q);
                state_q <= StOut;
              end
            endcase
          end
        end
        StFrontW: begin
          front_q <= rtime_q;
          state_q <= StBackW;
        end
        StBackW: begin
          if (cmd_q.op == OpPush) begin
            if (held_new > cap_eff) begin
              oldest_q <= slot(oldest_new, held_new - cap_eff);
              held_q <= cap_eff;
              res_q.entry_count <= 9'(cap_eff);
            end else begin
              oldest_q <= oldest_new;
              held_q <= held_new;
              res_q.entry_count <= 9'(held_new);
            end
            state_q <= StOut;
          end else begin
            res_q.entry_count <= 9'(held_q);
            if (cmd_q.time_req <= front_q) begin
              res_q.status <= StatNotFound;
              state_q <= StOut;
            end else if (cmd_q.time_req > rtime_q) begin
              if (diff_back > (TimeW+1)'(ahead_tol_i)) begin
                res_q.status <= StatTooNew;
                state_q <= StOut;
              end else begin
                pos_q <= held_q - CW'(1);
                raddr_q <= slot(oldest_q, held_q - CW'(1));
                state_q <= StFetch;
              end
            end else begin
              lo_q <= '0;
              hi_q <= held_q - CW'(1);
              state_q <= StSearch;
            end
          end
        end
        StFront: begin
          if (held_q == '0) begin
            res_q.status <= StatNotFound;
            res_q.entry_count <= '0;
            state_q <= StOut;
          end else begin
            raddr_q <= slot(oldest_q, held_q - CW'(1));
            state_q <= StFrontW;
          end
        end
        StSearch: begin
          if (lo_q < hi_q) begin
            raddr_q <= slot(oldest_q, mid);
            state_q <= StSearchW;
          end else begin
            raddr_q <= slot(oldest_q, lo_q);
            state_q <= StAt;
          end
        end
        StSearchW: state_q <= StAtW;
        StAtW: begin
          if (rtime_q < cmd_q.time_req) begin
            lo_q <= mid + CW'(1);
          end else begin
            hi_q <= mid;
          end
          state_q <= StSearch;
        end
        StAt: begin
          raddr_q <= slot(oldest_q, lo_q - CW'(1));
          state_q <= StPrev;
        end
        StPrev: begin
          at_q <= rtime_q;
          state_q <= StPrevW;
        end
        StPrevW: begin
          if (at_q == cmd_q.time_req || lo_q == '0) begin
            pos_q <= lo_q;
            raddr_q <= slot(oldest_q, lo_q);
          end else if (d_dn > d_up) begin
            pos_q <= lo_q;
            raddr_q <= slot(oldest_q, lo_q);
          end else begin
            pos_q <= lo_q - CW'(1);
            raddr_q <= slot(oldest_q, lo_q - CW'(1));
          end
          state_q <= StFetch;
        end
        StFetch: state_q <= StFetchW;
        StFetchW: begin
          res_q.found_index <= pos_q[7:0];
          res_q.found_payload <= rpay_q;
          res_q.found_loc_state <= rloc_q;
          res_q.status <= (cmd_q.full_query && rloc_q == LocBad) ? StatBadLoc : StatOk;
          state_q <= StOut;
        end
        StOut: begin
          if (!out_valid_q || out_if.ready) begin
            out_q <= res_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`include "timestamped_pose_buffer_lookup_macros.svh"
  `TPB_ASSERT(a_held_max, clk_i, rst_ni, held_q <= CW'(DEPTH), "held count beyond depth")
  `TPB_ASSERT(a_ready_idle, clk_i, rst_ni, cmd_ready_o |-> (state_q == StIdle),
    "command taken while busy")
  `TPB_ASSERT(a_out_once, clk_i, rst_ni, (state_q == StOut && !out_valid_q) |=> out_valid_q,
    "result not issued")
endmodule

[rtl/timestamped_pose_buffer_lookup.sv]
// Top level of the timestamped pose buffer with nearest-time lookup.
// Items are taken by a two-entry front queue and executed one at a time by
// the back end, whose single registered memory read port paces pushes and queries;
// each binary search step of a query waits for its registered memory read.
// Results wait in an output register while the next item is accepted.
module timestamped_pose_buffer_lookup import tpb_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  tpb_in_if.sink in_if,
  tpb_out_if.source out_if,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);
  logic [8:0] capacity_q;
  logic [CfgW-1:0] gap_q, tol_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 9'd256;
      gap_q <= CfgW'(300000);
      tol_q <= CfgW'(100000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCapacity: capacity_q <= cfg_data_i[8:0];
        CfgGapLimit: gap_q <= cfg_data_i;
        CfgAheadTol: tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpb_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  tpb_back #(.DEPTH(DEPTH)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .capacity_i(capacity_q), .gap_limit_i(gap_q), .ahead_tol_i(tol_q),
    .out_if(out_if)
  );
endmodule

[bench/tb_timestamped_pose_buffer_lookup.sv]
// Testbench for the timestamped pose buffer: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module tb_timestamped_pose_buffer_lookup;
  import tpb_pkg::*;

  typedef struct {
    logic [2:0] kind;
    logic [TimeW-1:0] t;
    logic [PayW-1:0] pay;
    logic [LocW-1:0] loc;
  } pose_item_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  tpb_in_if in_if ();
  tpb_out_if out_if ();

  timestamped_pose_buffer_lookup i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  pose_item_t pending_q[$];
  res_t expected_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_phase = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  logic [TimeW-1:0] time_mem[256];
  logic [PayW-1:0] pay_mem[256];
  logic [LocW-1:0] loc_mem[256];
  int oldest = 0;
  int held = 0;
  int capacity = 256;
  logic [CfgW-1:0] gap_lim = 24'd300000;
  logic [CfgW-1:0] ahead_tol = 24'd100000;
  logic [TimeW-1:0] gen_time = '0;

  function automatic logic [TimeW-1:0] time_at(int pos);
    return time_mem[(oldest + pos) % 256];
  endfunction

  function automatic res_t predict_lookup(pose_item_t it);
    res_t r;
    int c, s, lo, hi, mid, pos;
    logic [TimeW-1:0] back, at, prev;
    r = '0;
    pos = -1;
    if (it.kind == KindPush) begin
      if (held > 0) begin
        back = time_at(held - 1);
        if (it.t < back || (it.t - back) > {24'd0, gap_lim}) begin
          held = 0;
          oldest = 0;
        end
      end
      if (held >= 256) begin
        oldest = (oldest + 1) % 256;
        held--;
      end
      s = (oldest + held) % 256;
      time_mem[s] = it.t;
      pay_mem[s] = it.pay;
      loc_mem[s] = it.loc;
      held++;
      c = capacity < CapMin ? CapMin : (capacity > 256 ? 256 : capacity);
      if (held > c) begin
        oldest = (oldest + held - c) % 256;
        held = c;
      end
    end else if (it.kind == KindFullQuery || it.kind == KindDrQuery) begin
      if (held == 0 || it.t <= time_at(0)) begin
        r.status = StatNotFound;
      end else if (it.t > time_at(held - 1)) begin
        if ((it.t - time_at(held - 1)) > {24'd0, ahead_tol}) r.status = StatTooNew;
        else pos = held - 1;
      end else begin
        lo = 0;
        hi = held - 1;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (time_at(mid) < it.t) lo = mid + 1;
          else hi = mid;
        end
        at = time_at(lo);
        if (at == it.t || lo == 0) begin
          pos = lo;
        end else begin
          prev = time_at(lo - 1);
          pos = ((it.t - prev) > (at - it.t)) ? lo : lo - 1;
        end
      end
      if (pos >= 0) begin
        s = (oldest + pos) % 256;
        r.found_index = pos[7:0];
        r.found_payload = pay_mem[s];
        r.found_loc_state = loc_mem[s];
        if (it.kind == KindFullQuery && loc_mem[s] == LocBad) r.status = StatBadLoc;
      end
    end else if (it.kind == KindClear) begin
      held = 0;
      oldest = 0;
    end
    r.entry_count = held[8:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Driver: offers the next pending item and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    pose_item_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.kind <= '0;
      in_if.time_req <= '0;
      in_if.payload <= '0;
      in_if.loc_state <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        nxt.kind = in_if.kind;
        nxt.t = in_if.time_req;
        nxt.pay = in_if.payload;
        nxt.loc = in_if.loc_state;
        expected_q.insert(expected_q.size(), predict_lookup(nxt));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          nxt = pending_q[0];
          pending_q.delete(0);
          in_if.valid <= 1'b1;
          in_if.kind <= nxt.kind;
          in_if.time_req <= nxt.t;
          in_if.payload <= nxt.pay;
          in_if.loc_state <= nxt.loc;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random ready, a long hold-off in one phase, and the result check.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (hold_phase && hold_cycles < 400) begin
        hold_cycles <= hold_cycles + 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", 64'(out_if.entry_count), 64'd0);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (out_if.status !== want.status)
            report("status", 64'(out_if.status), 64'(want.status));
          if (out_if.found_index !== want.found_index)
            report("found_index", 64'(out_if.found_index), 64'(want.found_index));
          if (out_if.found_payload !== want.found_payload)
            report("found_payload", out_if.found_payload, want.found_payload);
          if (out_if.found_loc_state !== want.found_loc_state)
            report("found_loc_state", 64'(out_if.found_loc_state), 64'(want.found_loc_state));
          if (out_if.entry_count !== want.entry_count)
            report("entry_count", 64'(out_if.entry_count), 64'(want.entry_count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("timestamped_pose_buffer_lookup test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add(logic [2:0] kind, logic [TimeW-1:0] t, logic [PayW-1:0] pay = '0,
                     logic [LocW-1:0] loc = '0);
    pose_item_t it;
    it.kind = kind;
    it.t = t;
    it.pay = pay;
    it.loc = loc;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CfgW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgCapacity: capacity = value & 32'h1ff;
      CfgGapLimit: gap_lim = value[CfgW-1:0];
      default: ahead_tol = value[CfgW-1:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_if.valid && expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_idling(int snd, int rcv);
    @(negedge clk_i);
    send_idle = snd;
    recv_idle = rcv;
  endtask

  task automatic gen_random(int n, int step_max, int break_pm);
    int r;
    logic [TimeW-1:0] t;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 58) begin
        if ($urandom_range(0, 999) < break_pm) begin
          case ($urandom_range(0, 2))
            0: t = gen_time - $urandom_range(1, 1000);
            1: t = gen_time + gap_lim + $urandom_range(1, 50000);
            default: t = TimeW'({$urandom, $urandom});
          endcase
        end else begin
          t = gen_time + $urandom_range(0, step_max);
        end
        gen_time = t;
        add(KindPush, t, {$urandom, $urandom},
            ($urandom_range(0, 3) == 0) ? LocBad : 8'($urandom_range(0, 255)));
      end else if (r < 90) begin
        case ($urandom_range(0, 4))
          0, 1: t = gen_time - $urandom_range(0, step_max * 40);
          2: t = gen_time;
          3: t = gen_time + $urandom_range(0, 2 * ahead_tol + 10);
          default: t = TimeW'({$urandom, $urandom});
        endcase
        add($urandom_range(0, 1) ? KindFullQuery : KindDrQuery, t, {$urandom, $urandom},
            8'($urandom));
      end else if (r < 93) begin
        add(KindClear, TimeW'({$urandom, $urandom}), {$urandom, $urandom}, 8'($urandom));
      end else if (r < 97) begin
        add(KindCount, TimeW'({$urandom, $urandom}), {$urandom, $urandom}, 8'($urandom));
      end else begin
        add(3'($urandom_range(5, 7)), TimeW'({$urandom, $urandom}), {$urandom, $urandom},
            8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgCapacity;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(16, 77);

    add(KindCount, '0);
    add(KindFullQuery, 48'd500);
    add(KindPush, 48'd1000, 64'h0, LocBad);
    add(KindFullQuery, 48'd1000);
    add(KindPush, 48'd2000, {64{1'b1}}, 8'd0);
    add(KindPush, 48'd3000, 64'h1234_5678_9abc_def0, LocBad);
    add(KindFullQuery, 48'd1500);
    add(KindDrQuery, 48'd1500);
    add(KindFullQuery, 48'd2500);
    add(KindFullQuery, 48'd2000);
    add(KindFullQuery, 48'd3000);
    add(KindDrQuery, 48'd103000);
    add(KindDrQuery, 48'd103001);
    add(KindPush, 48'd2999, 64'h5, 8'hff);
    add(KindPush, 48'd302999, 64'h6, 8'd1);
    add(KindPush, 48'd603000, 64'h7, 8'd2);
    add(KindPush, {TimeW{1'b1}}, {64{1'b1}}, 8'hff);
    add(KindFullQuery, {TimeW{1'b1}});
    add(KindPush, '0, 64'h8, 8'd0);
    add(3'd5, 48'd9, 64'h9, 8'd9);
    add(3'd6, {TimeW{1'b1}}, 64'h0, 8'd0);
    add(3'd7, 48'd1, 64'h1, 8'd1);
    add(KindClear, '0);
    add(KindCount, '0);
    drain();

    write_reg(CfgCapacity, 50);
    write_reg(CfgGapLimit, 24'hffffff);
    write_reg(CfgAheadTol, 0);
    gen_time = 48'd5000;
    @(negedge clk_i);
    hold_phase = 1'b1;
    gen_random(450, 20000, 10);
    drain();

    set_idling(77, 16);
    @(negedge clk_i);
    hold_phase = 1'b0;
    write_reg(CfgCapacity, 511);
    write_reg(CfgGapLimit, 20000);
    write_reg(CfgAheadTol, 24'hffffff);
    gen_random(600, 20000, 2);
    drain();

    set_idling(0, 0);
    write_reg(CfgCapacity, 0);
    write_reg(CfgGapLimit, 0);
    write_reg(CfgAheadTol, 5000);
    gen_random(350, 1, 5);
    drain();

    write_reg(CfgCapacity, 130);
    write_reg(CfgGapLimit, 300000);
    write_reg(CfgAheadTol, 100000);
    gen_random(450, 40000, 15);
    drain();

    if (errors == 0) begin
      $display("timestamped_pose_buffer_lookup test passed");
    end else begin
      $display("timestamped_pose_buffer_lookup test failed");
    end
    $finish;
  end
endmodule
